// ===== rtl/core/wmms_pkg.sv =====
// ----------------------------------------------------------------------------
// wmms_pkg
// Shared widths, types, register codes and helpers for the windowed
// min / max / sum statistics block.
// ----------------------------------------------------------------------------
package wmms_pkg;

  // Widths
  localparam int SAMPLE_BITS = 12;
  localparam int NUM_CH      = 5;
  localparam int CH_W        = 3;
  localparam int SUM_W       = 28;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int PROD_W      = 2 * SAMPLE_BITS;

  // Accumulator memory: two banks, one window each
  localparam int BANK_DEPTH = 2;

  // Constants
  localparam logic [SUM_W-1:0]       SUM_MAX      = '1;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX   = '1;
  localparam logic [CNT_W-1:0]       CNT_MAX      = '1;
  localparam logic [CNT_W-1:0]       WINDOW_RESET = CNT_W'(1008);
  localparam logic [PROD_W-1:0]      POWER_ROUND  = PROD_W'(9'h1FF);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SCANS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_OFFSET = CFG_IDX_W'(1);

  // Channel codes
  localparam logic [CH_W-1:0] CH_CURRENT = CH_W'(0);
  localparam logic [CH_W-1:0] CH_POWER   = CH_W'(NUM_CH - 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    sample_t          max_v;
    sample_t          min_v;
  } chan_stat_t;

  typedef chan_stat_t [NUM_CH-1:0] stat_word_t;

  localparam int STAT_W = $bits(stat_word_t);

  // Accumulators of an empty window
  function automatic stat_word_t stat_clear();
    stat_word_t w;
    for (int c = 0; c < NUM_CH; c++) begin
      w[c].sum   = '0;
      w[c].max_v = '0;
      w[c].min_v = SAMPLE_MAX;
    end
    return w;
  endfunction

  // Offset removal, clamped at zero
  function automatic sample_t correct_sample(sample_t raw, sample_t offset);
    return (raw > offset) ? sample_t'(raw - offset) : '0;
  endfunction

  // One channel: saturating sum, running max and min
  function automatic chan_stat_t stat_update(chan_stat_t s, sample_t v);
    chan_stat_t         r;
    logic [SUM_W:0]     wide;
    wide    = {1'b0, s.sum} + (SUM_W + 1)'(v);
    r.sum   = (wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : wide[SUM_W-1:0];
    r.max_v = (v > s.max_v) ? v : s.max_v;
    r.min_v = (v < s.min_v) ? v : s.min_v;
    return r;
  endfunction

endpackage

// ===== rtl/core/wmms_ram.sv =====
// ----------------------------------------------------------------------------
// wmms_ram
// Generic RAM: one write port, two read ports, registered read data that
// holds while its read enable is low.
// ----------------------------------------------------------------------------
module wmms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic                     rd_en_b,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en_a) begin
      rd_data_a <= mem[rd_addr_a];
    end
    if (rd_en_b) begin
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/core/multichannel_window_min_max_sum.sv =====
// ----------------------------------------------------------------------------
// multichannel_window_min_max_sum
// Per-scan offset removal, derived power channel, and windowed sum / max /
// min statistics for five channels, emitted as five items per window.
// ----------------------------------------------------------------------------
//
//   port group   | dir | handshake           | carries
//   -------------+-----+---------------------+---------------------------------
//   in_*         | in  | in_valid / in_stall | four raw 12-bit samples per scan
//   out_*        | out | out_valid/out_stall | channel, sum, max, min, total, last
//   cfg_*        | in  | cfg_valid/cfg_ready | register index and write data
//
// One scan is accepted per cycle unless in_stall is high; it passes the offset,
// multiply and read-modify-write stages into the accumulator memory. A closing
// window sends five items from its bank, one per cycle unless out_stall is high;
// a second close waits while the previous window's items are still being sent.
// Reset is synchronous; two bank valid bits make a fresh bank read as empty,
// so no clearing pass is run. Output stalls back up through the pipeline.
//
module multichannel_window_min_max_sum (
  input  logic                                  clk,
  input  logic                                  rst,
  // Scan input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wmms_pkg::SAMPLE_BITS-1:0]      current_sample,
  input  logic [wmms_pkg::SAMPLE_BITS-1:0]      voltage_sample,
  input  logic [wmms_pkg::SAMPLE_BITS-1:0]      reference_sample,
  input  logic [wmms_pkg::SAMPLE_BITS-1:0]      temperature_sample,
  // Statistics output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [wmms_pkg::CH_W-1:0]             channel,
  output logic [wmms_pkg::SUM_W-1:0]            window_sum,
  output logic [wmms_pkg::SAMPLE_BITS-1:0]      window_max,
  output logic [wmms_pkg::SAMPLE_BITS-1:0]      window_min,
  output logic [wmms_pkg::CNT_W-1:0]            scan_total,
  output logic                                  last,
  // Configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wmms_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wmms_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // Configuration registers
  logic [wmms_pkg::CNT_W-1:0] window_scans;
  wmms_pkg::sample_t          sample_offset;

  // Pipeline
  logic              s1_valid, s2_valid, s3_valid;
  logic              s1_ready, s2_ready, s3_ready;
  logic              s2_move, s3_fire;
  wmms_pkg::sample_t s1_val [4];
  wmms_pkg::sample_t s2_val [wmms_pkg::NUM_CH];
  wmms_pkg::sample_t s3_val [wmms_pkg::NUM_CH];
  logic [wmms_pkg::PROD_W-1:0] power_prod;

  // Accumulator state
  logic                       bank;
  logic                       bank_rd;
  logic [1:0]                 bank_valid;
  logic [wmms_pkg::CNT_W-1:0] scan_count;
  logic [wmms_pkg::CNT_W-1:0] scan_count_next;
  logic                       fwd_hit;
  wmms_pkg::stat_word_t       fwd_data;
  wmms_pkg::stat_word_t       acc_rdata;
  wmms_pkg::stat_word_t       acc_base;
  wmms_pkg::stat_word_t       acc_next;
  logic                       close;

  // Emission
  logic                       em_rd;
  logic                       em_active;
  logic                       em_busy;
  logic                       em_bank;
  logic [wmms_pkg::CH_W-1:0]  em_ch;
  logic [wmms_pkg::CNT_W-1:0] em_total;
  wmms_pkg::stat_word_t       em_word;
  logic                       out_load;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_scans  <= wmms_pkg::WINDOW_RESET;
      sample_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wmms_pkg::REG_WINDOW_SCANS:  window_scans  <= cfg_data;
        wmms_pkg::REG_SAMPLE_OFFSET: sample_offset <= cfg_data[wmms_pkg::SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  assign s3_ready = !s3_valid || s3_fire;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign s2_move  = s2_valid && s3_ready;
  assign in_stall = !s1_ready;

  // Stage 1: offset removal
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_val[0] <= wmms_pkg::correct_sample(current_sample, sample_offset);
      s1_val[1] <= wmms_pkg::correct_sample(voltage_sample, sample_offset);
      s1_val[2] <= wmms_pkg::correct_sample(reference_sample, sample_offset);
      s1_val[3] <= wmms_pkg::correct_sample(temperature_sample, sample_offset);
    end
  end

  // Stage 2: power = (current * voltage + round) >> SAMPLE_BITS
  assign power_prod = wmms_pkg::PROD_W'(s1_val[0]) * wmms_pkg::PROD_W'(s1_val[1])
                    + wmms_pkg::POWER_ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      for (int c = 0; c < 4; c++) begin
        s2_val[c] <= s1_val[c];
      end
      s2_val[wmms_pkg::NUM_CH-1] <=
        power_prod[wmms_pkg::PROD_W-1:wmms_pkg::SAMPLE_BITS];
    end
  end

  // Stage 3 register; the memory read is issued on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_val <= s2_val;
    end
  end

  // --------------------------------------------------------------------------
  // Accumulator memory
  // --------------------------------------------------------------------------
  // Read the bank that is active after this edge
  assign bank_rd = (s3_fire && close) ? ~bank : bank;

  wmms_ram #(
    .WIDTH (wmms_pkg::STAT_W),
    .DEPTH (wmms_pkg::BANK_DEPTH)
  ) u_acc_ram (
    .clk       (clk),
    .wr_en     (s3_fire),
    .wr_addr   (bank),
    .wr_data   (acc_next),
    .rd_en_a   (s2_move),
    .rd_addr_a (bank_rd),
    .rd_data_a (acc_rdata),
    .rd_en_b   (em_rd),
    .rd_addr_b (em_bank),
    .rd_data_b (em_word)
  );

  // Forward a write that lands on the edge of the read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (s2_move) begin
      fwd_hit <= s3_fire && !close;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      fwd_data <= acc_next;
    end
  end

  // Read-modify-write of all five channels
  always_comb begin
    if (fwd_hit) begin
      acc_base = fwd_data;
    end else if (bank_valid[bank]) begin
      acc_base = acc_rdata;
    end else begin
      acc_base = wmms_pkg::stat_clear();
    end
    for (int c = 0; c < wmms_pkg::NUM_CH; c++) begin
      acc_next[c] = wmms_pkg::stat_update(acc_base[c], s3_val[c]);
    end
  end

  // Scan counter saturates; a window closes once it reaches the length
  assign scan_count_next = (scan_count == wmms_pkg::CNT_MAX) ? scan_count
                                                             : scan_count + 1'b1;
  assign close   = scan_count_next >= window_scans;
  assign em_busy = em_rd || em_active;
  assign s3_fire = s3_valid && !(close && em_busy);

  always_ff @(posedge clk) begin
    if (rst) begin
      bank       <= 1'b0;
      bank_valid <= '0;
      scan_count <= '0;
    end else if (s3_fire) begin
      if (close) begin
        bank             <= ~bank;
        bank_valid[~bank] <= 1'b0;
        scan_count       <= '0;
      end else begin
        bank_valid[bank] <= 1'b1;
        scan_count       <= scan_count_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Emission of a closed window, one channel per item
  // --------------------------------------------------------------------------
  assign out_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      em_rd     <= 1'b0;
      em_active <= 1'b0;
      em_ch     <= wmms_pkg::CH_CURRENT;
      out_valid <= 1'b0;
    end else begin
      em_rd <= s3_fire && close;
      if (em_rd) begin
        em_active <= 1'b1;
        em_ch     <= wmms_pkg::CH_CURRENT;
      end
      if (em_active && out_load) begin
        out_valid <= 1'b1;
        em_ch     <= em_ch + 1'b1;
        if (em_ch == wmms_pkg::CH_POWER) begin
          em_active <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Closed bank and scan total, captured at the close
  always_ff @(posedge clk) begin
    if (s3_fire && close) begin
      em_bank  <= bank;
      em_total <= scan_count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (em_active && out_load) begin
      channel    <= em_ch;
      window_sum <= em_word[em_ch].sum;
      window_max <= em_word[em_ch].max_v;
      window_min <= em_word[em_ch].min_v;
      scan_total <= em_total;
      last       <= (em_ch == wmms_pkg::CH_POWER);
    end
  end

endmodule

// ===== tb/multichannel_window_min_max_sum_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_window_min_max_sum_tb
// Drives ADC scans and register writes into the windowed statistics block
// and checks every statistics item against a cycle-free model of the
// accumulators. A short table of directed rows comes first. Random phases
// with varied window and offset settings and with sender and receiver
// idling follow. One phase holds the output off long enough to back the
// block up.
// ----------------------------------------------------------------------------
module multichannel_window_min_max_sum_tb;

  localparam int                         DRAIN_CYCLES    = 16;
  localparam int                         WATCHDOG_LIMIT  = 3000;
  localparam int                         LONG_HOLD       = 300;
  localparam int                         MAX_REPORTS     = 10;
  localparam int                         ITEMS_PER_PHASE = 30;
  localparam logic [wmms_pkg::CNT_W-1:0] WINDOW_AT_RESET = 16'd1008;
  localparam int                         ROUNDING        = 'h1FF;

  // Indexes outside the register map; writes to them are dropped
  localparam logic [wmms_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = wmms_pkg::CFG_IDX_W'(2);
  localparam logic [wmms_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = wmms_pkg::CFG_IDX_W'(3);

  typedef wmms_pkg::sample_t [3:0]                  scan_t;
  typedef wmms_pkg::sample_t [wmms_pkg::NUM_CH-1:0] chan_vals_t;

  typedef struct packed {
    logic [wmms_pkg::CH_W-1:0]  ch;
    logic [wmms_pkg::SUM_W-1:0] sum;
    wmms_pkg::sample_t          hi;
    wmms_pkg::sample_t          lo;
    logic [wmms_pkg::CNT_W-1:0] total;
    logic                       fin;
  } stat_item_t;

  typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [wmms_pkg::CFG_IDX_W-1:0]  idx;
    logic [wmms_pkg::CFG_DATA_W-1:0] data;
    scan_t                           raw;
    logic                            typed;
    chan_vals_t                      vals;
  } dir_row_t;

  // Block ports
  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  wmms_pkg::sample_t               current_sample = '0;
  wmms_pkg::sample_t               voltage_sample = '0;
  wmms_pkg::sample_t               reference_sample = '0;
  wmms_pkg::sample_t               temperature_sample = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [wmms_pkg::CH_W-1:0]       channel;
  logic [wmms_pkg::SUM_W-1:0]      window_sum;
  wmms_pkg::sample_t               window_max;
  wmms_pkg::sample_t               window_min;
  logic [wmms_pkg::CNT_W-1:0]      scan_total;
  logic                            last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [wmms_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wmms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Model state and registers
  logic [wmms_pkg::SUM_W-1:0] acc_sum [wmms_pkg::NUM_CH];
  wmms_pkg::sample_t          acc_hi [wmms_pkg::NUM_CH];
  wmms_pkg::sample_t          acc_lo [wmms_pkg::NUM_CH];
  logic [wmms_pkg::CNT_W-1:0] scans_seen;
  logic [wmms_pkg::CNT_W-1:0] win_len;
  wmms_pkg::sample_t          offset_reg;

  stat_item_t pending_stats [$];
  int         mismatches = 0;
  int         idle_pct = 0;
  int         stall_pct = 0;
  logic       hold_arm = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;
  int         stuck_cycles = 0;

  always #10 clk = ~clk;

  multichannel_window_min_max_sum DUT (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .current_sample     (current_sample),
    .voltage_sample     (voltage_sample),
    .reference_sample   (reference_sample),
    .temperature_sample (temperature_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .channel            (channel),
    .window_sum         (window_sum),
    .window_max         (window_max),
    .window_min         (window_min),
    .scan_total         (scan_total),
    .last               (last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // Accumulators of an empty window
  function automatic void empty_window();
    for (int c = 0; c < wmms_pkg::NUM_CH; c++) begin
      acc_sum[c] = '0;
      acc_hi[c]  = '0;
      acc_lo[c]  = '1;
    end
    scans_seen = '0;
  endfunction

  // Folds one scan into the window; queues five items when it closes, if queue_items is set
  function automatic void accumulate_scan(input scan_t raw, input bit queue_items);
    wmms_pkg::sample_t           v [wmms_pkg::NUM_CH];
    logic [wmms_pkg::PROD_W-1:0] prod;
    logic [wmms_pkg::SUM_W:0]    wide;
    stat_item_t                  r;
    for (int c = 0; c < 4; c++)
      v[c] = (raw[c] > offset_reg) ? wmms_pkg::sample_t'(raw[c] - offset_reg) : '0;
    prod = wmms_pkg::PROD_W'(v[0]) * wmms_pkg::PROD_W'(v[1]) + wmms_pkg::PROD_W'(ROUNDING);
    v[wmms_pkg::NUM_CH-1] = prod[wmms_pkg::SAMPLE_BITS +: wmms_pkg::SAMPLE_BITS];
    for (int c = 0; c < wmms_pkg::NUM_CH; c++) begin
      wide = {1'b0, acc_sum[c]} + (wmms_pkg::SUM_W + 1)'(v[c]);
      acc_sum[c] = wide[wmms_pkg::SUM_W] ? '1 : wide[wmms_pkg::SUM_W-1:0];
      if (v[c] > acc_hi[c]) acc_hi[c] = v[c];
      if (v[c] < acc_lo[c]) acc_lo[c] = v[c];
    end
    if (scans_seen != '1) scans_seen++;
    if (scans_seen < win_len) return;
    if (queue_items) begin
      for (int c = 0; c < wmms_pkg::NUM_CH; c++) begin
        r.ch    = wmms_pkg::CH_W'(c);
        r.sum   = acc_sum[c];
        r.hi    = acc_hi[c];
        r.lo    = acc_lo[c];
        r.total = scans_seen;
        r.fin   = (wmms_pkg::CH_W'(c) == wmms_pkg::CH_POWER);
        pending_stats.push_back(r);
      end
    end
    empty_window();
  endfunction

  // Compares one accepted statistics item with the oldest expectation
  function automatic void check_stat();
    stat_item_t want;
    stat_item_t got;
    got = {channel, window_sum, window_max, window_min, scan_total, last};
    if (pending_stats.size() == 0) begin
      if (mismatches < MAX_REPORTS)
        $display("unexpected item: ch %0d sum %0d max %0d min %0d total %0d last %0b",
                 got.ch, got.sum, got.hi, got.lo, got.total, got.fin);
      mismatches++;
      return;
    end
    want = pending_stats.pop_front();
    if (got.ch !== want.ch || got.sum !== want.sum || got.hi !== want.hi ||
        got.lo !== want.lo || got.total !== want.total || got.fin !== want.fin) begin
      if (mismatches < MAX_REPORTS) begin
        $display("mismatch exp: ch %0d sum %0d max %0d min %0d total %0d last %0b",
                 want.ch, want.sum, want.hi, want.lo, want.total, want.fin);
        $display("         got: ch %0d sum %0d max %0d min %0d total %0d last %0b",
                 got.ch, got.sum, got.hi, got.lo, got.total, got.fin);
      end
      mismatches++;
    end
  endfunction

  // Receiver: checks items, stalls at random, one long hold-off on request
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) check_stat();
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: cycles in a row with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Drops the input, waits for all items, then lets the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wmms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wmms_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      wmms_pkg::REG_WINDOW_SCANS:  win_len = data;
      wmms_pkg::REG_SAMPLE_OFFSET: offset_reg = data[wmms_pkg::SAMPLE_BITS-1:0];
      default: ;
    endcase
  endtask

  // Offers one scan after a random gap; predicts once it is taken
  task automatic push_scan(input scan_t raw, input bit queue_items);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    current_sample     <= raw[0];
    voltage_sample     <= raw[1];
    reference_sample   <= raw[2];
    temperature_sample <= raw[3];
    do @(posedge clk); while (in_stall !== 1'b0);
    accumulate_scan(raw, queue_items);
  endtask

  function automatic dir_row_t scan_row(input wmms_pkg::sample_t cur, vol, rfc, tmp);
    dir_row_t r;
    r        = '0;
    r.kind   = ROW_SCAN;
    r.raw[0] = cur;
    r.raw[1] = vol;
    r.raw[2] = rfc;
    r.raw[3] = tmp;
    return r;
  endfunction

  // Scan in a one-scan window: sum, max and min all equal the channel value
  function automatic dir_row_t typed_row(input wmms_pkg::sample_t cur, vol, rfc, tmp,
                                         input wmms_pkg::sample_t e0, e1, e2, e3, e4);
    dir_row_t r;
    r         = scan_row(cur, vol, rfc, tmp);
    r.typed   = 1'b1;
    r.vals[0] = e0;
    r.vals[1] = e1;
    r.vals[2] = e2;
    r.vals[3] = e3;
    r.vals[4] = e4;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [wmms_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [wmms_pkg::CFG_DATA_W-1:0] data);
    dir_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  // Mostly uniform, with the rails mixed in
  function automatic wmms_pkg::sample_t random_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return wmms_pkg::sample_t'($urandom_range(4095, 0));
    endcase
  endfunction

  function automatic scan_t random_scan();
    scan_t s;
    for (int c = 0; c < 4; c++) s[c] = random_sample();
    return s;
  endfunction

  function automatic logic [wmms_pkg::CFG_DATA_W-1:0] random_window();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 35) return wmms_pkg::CFG_DATA_W'($urandom_range(3, 1));
    if (pick < 90) return wmms_pkg::CFG_DATA_W'($urandom_range(12, 4));
    return wmms_pkg::CFG_DATA_W'($urandom_range(40, 13));
  endfunction

  // Upper nibble is junk above the 12-bit register
  function automatic logic [wmms_pkg::CFG_DATA_W-1:0] random_offset();
    int pick;
    int off;
    pick = $urandom_range(99);
    if (pick < 40)      off = $urandom_range(63, 0);
    else if (pick < 80) off = $urandom_range(1023, 0);
    else                off = $urandom_range(4095, 0);
    return {4'($urandom_range(15, 0)), wmms_pkg::sample_t'(off)};
  endfunction

  initial begin
    dir_row_t   plan [$];
    stat_item_t r;
    int         idle_by_phase [4];
    int         stall_by_phase [4];

    idle_by_phase  = '{0, 70, 0, 29};
    stall_by_phase = '{0, 0, 70, 29};
    empty_window();
    win_len    = WINDOW_AT_RESET;
    offset_reg = '0;

    // Reset window length, then shortened below the count reached
    plan.push_back(scan_row(100, 200, 300, 400));
    plan.push_back(scan_row(4095, 0, 4095, 0));
    plan.push_back(cfg_row(wmms_pkg::REG_WINDOW_SCANS, 16'd2));
    plan.push_back(scan_row(5, 6, 7, 8));
    // One-scan windows at the rails
    plan.push_back(cfg_row(wmms_pkg::REG_WINDOW_SCANS, 16'd1));
    plan.push_back(typed_row(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4094));
    plan.push_back(typed_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(typed_row(4095, 1, 2048, 2730, 4095, 1, 2048, 2730, 1));
    // Offset with junk in the upper bits; samples around it clamp to zero
    plan.push_back(cfg_row(wmms_pkg::REG_SAMPLE_OFFSET, 16'hF010));
    plan.push_back(typed_row(16, 15, 17, 4095, 0, 0, 1, 4079, 0));
    plan.push_back(cfg_row(wmms_pkg::REG_SAMPLE_OFFSET, 16'h0FFF));
    plan.push_back(typed_row(4095, 4095, 4095, 4095, 0, 0, 0, 0, 0));
    // Writes outside the register map change nothing
    plan.push_back(cfg_row(REG_SPARE_2, 16'hFFFF));
    plan.push_back(cfg_row(REG_SPARE_3, 16'h5555));
    plan.push_back(typed_row(4095, 2048, 4095, 4095, 0, 0, 0, 0, 0));
    // Zero window length behaves as one
    plan.push_back(cfg_row(wmms_pkg::REG_SAMPLE_OFFSET, 16'h0000));
    plan.push_back(cfg_row(wmms_pkg::REG_WINDOW_SCANS, 16'd0));
    plan.push_back(typed_row(2048, 2048, 2048, 2048, 2048, 2048, 2048, 2048, 1024));
    plan.push_back(typed_row(4095, 4095, 1, 1, 4095, 4095, 1, 1, 4094));
    // Longest window, cut short after a few scans
    plan.push_back(cfg_row(wmms_pkg::REG_WINDOW_SCANS, 16'hFFFF));
    plan.push_back(scan_row(1234, 2345, 3456, 567));
    plan.push_back(scan_row(4095, 4095, 0, 0));
    plan.push_back(scan_row(7, 4000, 99, 3000));
    plan.push_back(cfg_row(wmms_pkg::REG_WINDOW_SCANS, 16'd3));
    plan.push_back(scan_row(10, 20, 30, 40));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    idle_pct = 20;
    stall_pct <= 20;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else if (plan[i].typed) begin
        push_scan(plan[i].raw, 1'b0);
        for (int c = 0; c < wmms_pkg::NUM_CH; c++) begin
          r.ch    = wmms_pkg::CH_W'(c);
          r.sum   = wmms_pkg::SUM_W'(plan[i].vals[c]);
          r.hi    = plan[i].vals[c];
          r.lo    = plan[i].vals[c];
          r.total = wmms_pkg::CNT_W'(1);
          r.fin   = (wmms_pkg::CH_W'(c) == wmms_pkg::CH_POWER);
          pending_stats.push_back(r);
        end
      end else begin
        push_scan(plan[i].raw, 1'b1);
      end
    end

    // Random phases, each with fresh registers and its own idling mix
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(wmms_pkg::REG_WINDOW_SCANS, random_window());
      write_reg(wmms_pkg::REG_SAMPLE_OFFSET, random_offset());
      idle_pct = idle_by_phase[ph % 4];
      stall_pct <= stall_by_phase[ph % 4];
      repeat (ITEMS_PER_PHASE) push_scan(random_scan(), 1'b1);
    end

    // Back-pressure: every scan closes a window while the output is held
    write_reg(wmms_pkg::REG_WINDOW_SCANS, 16'd1);
    idle_pct = 0;
    stall_pct <= 0;
    hold_arm <= 1'b1;
    repeat (ITEMS_PER_PHASE) push_scan(random_scan(), 1'b1);

    wait_idle();
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== multichannel_window_min_max_sum.f =====
rtl/core/wmms_pkg.sv
rtl/core/wmms_ram.sv
rtl/core/multichannel_window_min_max_sum.sv
tb/multichannel_window_min_max_sum_tb.sv
